FILE: rtl/ust_pkg.sv
// ----------------------------------------------------------------------------
// Unsorted set table package
// Sizes, command and status codes, word types and the walk state type that
// the unsorted set table uses.
// ----------------------------------------------------------------------------
package ust_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;

    // Slot index and fill count widths; the count must be able to hold DEPTH.
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] FN_FIND       = 3'd0;
    localparam logic [2:0] FN_INSERT     = 3'd1;
    localparam logic [2:0] FN_UPDATE     = 3'd2;
    localparam logic [2:0] FN_REMOVE     = 3'd3;
    localparam logic [2:0] FN_REMOVE_ALL = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_PRESENT   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] key;
        logic signed [31:0] new_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] position;
        logic [4:0] entry_count;
        logic [4:0] removed_count;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

endpackage

FILE: rtl/unsorted_set_table.sv
// ----------------------------------------------------------------------------
// Unsorted set table
// Packed table of signed words with find, insert, update, remove and
// remove-all commands, walked slot by slot through a synchronous memory.
// ----------------------------------------------------------------------------
// An accepted command word walks the filled slots in S_WALK and then writes its
// result word in S_FINISH; no new command is taken until the table is back in
// S_IDLE. The walk reads one slot per cycle through the single read port of the
// table memory, and a result word held by the receiver also holds the finish step.
// Reset clears the fill count and the control state; the table memory itself
// is not swept, as slots at or above the fill count are never read.
module unsorted_set_table
    import ust_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    word_t mem [DEPTH];
    word_t mem_q;

    state_t state_reg, state_next;

    logic [2:0]       func_reg, func_next;
    word_t            word_reg, word_next;
    word_t            repl_reg, repl_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] cur_idx_reg, cur_idx_next;
    logic             dvld_reg, dvld_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_slot_reg, hit_slot_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;

    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    word_t            mem_wdata;

    logic issue;
    logic match;
    logic is_remove;
    logic skip;
    logic finish_go;
    logic accept;

    assign accept    = cmd_valid && !cmd_stall;
    assign issue     = rd_ptr_reg < fill_reg;
    assign match     = dvld_reg && (mem_q == word_reg);
    assign is_remove = (func_reg == FN_REMOVE) || (func_reg == FN_REMOVE_ALL);
    assign skip      = match && ((func_reg == FN_REMOVE_ALL) ||
                                 ((func_reg == FN_REMOVE) && !hit_reg));
    assign finish_go = !out_valid_reg || !rsp_stall;

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Table memory: one write port and one registered read port. During the
    // walk the write slot never passes the slot being read, so the two never
    // meet on the same entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (!issue && !dvld_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        func_next      = func_reg;
        word_next      = word_reg;
        repl_next      = repl_reg;
        fill_next      = fill_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        cur_idx_next   = cur_idx_reg;
        dvld_next      = 1'b0;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_ptr_reg[IDX_W-1:0];
        mem_we         = 1'b0;
        mem_waddr      = wr_ptr_reg[IDX_W-1:0];
        mem_wdata      = mem_q;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next     = cmd.func;
                    word_next     = WORD_BITS'(cmd.key);
                    repl_next     = WORD_BITS'(cmd.new_value);
                    rd_ptr_next   = '0;
                    wr_ptr_next   = '0;
                    hit_next      = 1'b0;
                    hit_slot_next = '0;
                end
            end
            S_WALK:
            begin
                mem_re       = issue;
                dvld_next    = issue;
                cur_idx_next = rd_ptr_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (match && !hit_reg)
                begin
                    hit_next      = 1'b1;
                    hit_slot_next = cur_idx_reg;
                end
                // Removals compact the survivors down to the write slot.
                if (dvld_reg && is_remove && !skip)
                begin
                    mem_we      = 1'b1;
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (finish_go)
                begin
                    out_valid_next         = 1'b1;
                    out_next.status        = ST_NOT_FOUND;
                    out_next.position      = hit_reg ? 4'(hit_slot_reg) : 4'd0;
                    out_next.removed_count = 5'd0;
                    case (func_reg)
                        FN_FIND:
                        begin
                            if (hit_reg)
                            begin
                                out_next.status = ST_OK;
                            end
                        end
                        FN_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                out_next.status = ST_PRESENT;
                            end
                            else if (fill_reg >= CNT_W'(DEPTH))
                            begin
                                out_next.status = ST_FULL;
                            end
                            else
                            begin
                                out_next.status = ST_OK;
                                mem_we          = 1'b1;
                                mem_waddr       = fill_reg[IDX_W-1:0];
                                mem_wdata       = word_reg;
                                fill_next       = fill_reg + 1'b1;
                            end
                        end
                        FN_UPDATE:
                        begin
                            if (hit_reg)
                            begin
                                out_next.status = ST_OK;
                                mem_we          = 1'b1;
                                mem_waddr       = hit_slot_reg;
                                mem_wdata       = repl_reg;
                            end
                        end
                        FN_REMOVE, FN_REMOVE_ALL:
                        begin
                            if (hit_reg)
                            begin
                                out_next.status = ST_OK;
                            end
                            fill_next              = wr_ptr_reg;
                            out_next.removed_count = 5'(fill_reg - wr_ptr_reg);
                        end
                        default:
                        begin
                            out_next.position = 4'd0;
                        end
                    endcase
                    out_next.entry_count = 5'(fill_next);
                end
            end
            default:
            begin
                dvld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            dvld_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            dvld_reg      <= dvld_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        word_reg     <= word_next;
        repl_reg     <= repl_next;
        cur_idx_reg  <= cur_idx_next;
        hit_slot_reg <= hit_slot_next;
        out_reg      <= out_next;
    end

    // The fill count never exceeds the table depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count above table depth");

    // Compaction writes never overtake the read pointer.
    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> wr_ptr_reg <= rd_ptr_reg)
        else $error("write slot ahead of read slot");

    // A new result word only appears once a walk has finished.
    a_rsp_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == S_FINISH)
        else $error("result word raised outside the finish step");

endmodule
